>>> design/shared_exclusive_lock_manager_macros.svh
// shared assertion macros for the lock manager
`ifndef SHARED_EXCLUSIVE_LOCK_MANAGER_MACROS_SVH
`define SHARED_EXCLUSIVE_LOCK_MANAGER_MACROS_SVH

// same-cycle implication
`define SLM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lock manager check failed");

// next-cycle implication
`define SLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lock manager check failed");

`endif

>>> design/slm_pkg.sv
`timescale 1ns / 1ps
package slm_pkg;
   localparam int OWNER_SLOTS  = 16;
   localparam int WAITER_SLOTS = 16;
   localparam int OIDX_W   = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
   localparam int WIDX_W   = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
   localparam int OCNT_W   = $clog2(2 * OWNER_SLOTS + 1);
   localparam int WCNT_W   = $clog2(WAITER_SLOTS + 1);
   localparam int SCAN_LEN = (OWNER_SLOTS > WAITER_SLOTS) ? OWNER_SLOTS : WAITER_SLOTS;
   localparam int SIDX_W   = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;

   localparam int ID_W    = 32;
   localparam int STAMP_W = 48;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 3;
   localparam int POL_W   = 2;
   localparam int MODE_W  = 2;

   localparam logic [OP_W-1:0] OP_SHARED  = 2'd0;
   localparam logic [OP_W-1:0] OP_EXCL    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

   localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SH   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EX   = 2'd2;

   localparam logic [POL_W-1:0] POL_NOWAIT  = 2'd0;
   localparam logic [POL_W-1:0] POL_WAITDIE = 2'd1;
   localparam logic [POL_W-1:0] POL_CALVIN  = 2'd2;
   localparam logic [POL_W-1:0] POL_SPARE   = 2'd3;

   localparam logic [STAT_W-1:0] RS_GRANT    = 3'd0;
   localparam logic [STAT_W-1:0] RS_WAIT     = 3'd1;
   localparam logic [STAT_W-1:0] RS_ABORT    = 3'd2;
   localparam logic [STAT_W-1:0] RS_REL      = 3'd3;
   localparam logic [STAT_W-1:0] RS_PROMO    = 3'd4;
   localparam logic [STAT_W-1:0] RS_NOTFOUND = 3'd5;
   localparam logic [STAT_W-1:0] RS_FULL     = 3'd6;

   typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_SCAN, S_APPLY, S_EMIT} state_type;

   typedef struct packed {
      logic load;
      logic quick;
      logic scan_step;
      logic apply;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic out_free;
      logic more;
   } stat_type;

   function automatic logic modes_clash(logic [MODE_W-1:0] a, logic [MODE_W-1:0] b);
      return (a != MODE_NONE) && (b != MODE_NONE) && ((a == MODE_EX) || (b == MODE_EX));
   endfunction
endpackage

>>> design/slm_datapath.sv
`timescale 1ns / 1ps
module slm_datapath import slm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [ID_W-1:0]     req_txn_id,
   input  logic [STAMP_W-1:0]  req_start_stamp,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [ID_W-1:0]     rsp_subject_id,
   output logic                rsp_last,
   input  logic                csr_wr_en,
   input  logic [POL_W-1:0]    csr_wr_data
);
   logic [POL_W-1:0]   policy_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [OCNT_W-1:0]  ocnt_ff;
   logic [WCNT_W-1:0]  wcnt_ff;
   logic [OWNER_SLOTS-1:0] ovalid_ff;
   logic [ID_W-1:0]    oid_ff [OWNER_SLOTS];
   logic [STAMP_W-1:0] ostamp_ff [OWNER_SLOTS];
   logic [ID_W-1:0]    wid_ff [WAITER_SLOTS];
   logic [STAMP_W-1:0] wstamp_ff [WAITER_SLOTS];
   logic               wex_ff [WAITER_SLOTS];

   logic [OP_W-1:0]    op_ff;
   logic [ID_W-1:0]    id_ff;
   logic [STAMP_W-1:0] stamp_ff;

   logic [SIDX_W-1:0]  sidx_ff;
   logic               hit_a_ff, hit_b_ff;
   logic [OIDX_W-1:0]  pos_a_ff;
   logic [WIDX_W-1:0]  pos_b_ff;

   logic [STAT_W-1:0]  pend_stat_ff, pend_stat_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic               promo_en_ff, promo_en_in;
   logic               pend_we;

   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic               rsp_last_ff;

   logic table_pol, is_acq, conflict, can_add, more, out_free;
   logic [MODE_W-1:0]  req_mode, head_mode;
   logic               free_hit;
   logic [OIDX_W-1:0]  free_pos;
   logic [OIDX_W-1:0]  s_o;
   logic [WIDX_W-1:0]  s_w;
   logic in_o, in_w, o_match, w_match;

   logic               add_en;
   logic [ID_W-1:0]    add_id;
   logic [STAMP_W-1:0] add_stamp;
   logic [MODE_W-1:0]  add_mode;
   logic               clr_en, rel_cnt_en;
   logic               ins_en, drop_en;
   logic [WIDX_W-1:0]  ins_pos, drop_pos;
   logic [OCNT_W-1:0]  ocnt_dec;

   assign table_pol = (policy_ff == POL_WAITDIE) || (policy_ff == POL_CALVIN);
   assign is_acq    = (op_ff == OP_SHARED) || (op_ff == OP_EXCL);
   assign req_mode  = (op_ff == OP_EXCL) ? MODE_EX : MODE_SH;
   assign head_mode = wex_ff[0] ? MODE_EX : MODE_SH;
   assign conflict  = modes_clash(mode_ff, req_mode) ||
                      ((wcnt_ff != '0) && (((policy_ff == POL_WAITDIE) &&
                        (stamp_ff < wstamp_ff[0])) || (policy_ff == POL_CALVIN)));

   always_comb begin
      free_hit = 1'b0;
      free_pos = '0;
      for (int i = OWNER_SLOTS - 1; i >= 0; i--) begin
         if (!ovalid_ff[i]) begin
            free_hit = 1'b1;
            free_pos = OIDX_W'(i);
         end
      end
   end

   assign can_add  = table_pol ? free_hit : (ocnt_ff < OCNT_W'(OWNER_SLOTS));
   assign more     = promo_en_ff && (wcnt_ff != '0) && !modes_clash(mode_ff, head_mode) &&
                     can_add;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ocnt_dec = (ocnt_ff != '0) ? ocnt_ff - OCNT_W'(1) : ocnt_ff;

   // scan of one owner entry and one waiter entry per cycle
   assign s_o  = sidx_ff[OIDX_W-1:0];
   assign s_w  = sidx_ff[WIDX_W-1:0];
   assign in_o = 32'(sidx_ff) < OWNER_SLOTS;
   assign in_w = 32'(sidx_ff) < 32'(wcnt_ff);
   assign o_match = in_o && ovalid_ff[s_o] &&
                    (is_acq ? (stamp_ff > ostamp_ff[s_o]) : (oid_ff[s_o] == id_ff));
   assign w_match = is_acq ? (!in_w || (stamp_ff >= wstamp_ff[s_w]))
                           : (in_w && (wid_ff[s_w] == id_ff));

   assign stat.need_scan = is_acq ? (conflict && (policy_ff == POL_WAITDIE)) : table_pol;
   assign stat.scan_done = sidx_ff == SIDX_W'(SCAN_LEN - 1);
   assign stat.out_free  = out_free;
   assign stat.more      = more;

   always_comb begin
      add_en       = 1'b0;
      add_id       = id_ff;
      add_stamp    = stamp_ff;
      add_mode     = req_mode;
      clr_en       = 1'b0;
      rel_cnt_en   = 1'b0;
      ins_en       = 1'b0;
      ins_pos      = pos_b_ff;
      drop_en      = 1'b0;
      drop_pos     = pos_b_ff;
      pend_we      = 1'b0;
      pend_stat_in = pend_stat_ff;
      pend_id_in   = id_ff;
      promo_en_in  = !is_acq;
      if (cmd.quick) begin
         pend_we = 1'b1;
         if (is_acq) begin
            if (!conflict) begin
               if (can_add) begin
                  add_en       = 1'b1;
                  pend_stat_in = RS_GRANT;
               end else begin
                  pend_stat_in = RS_FULL;
               end
            end else if (policy_ff == POL_CALVIN) begin
               if (wcnt_ff == WCNT_W'(WAITER_SLOTS)) begin
                  pend_stat_in = RS_FULL;
               end else begin
                  ins_en       = 1'b1;
                  ins_pos      = wcnt_ff[WIDX_W-1:0];
                  pend_stat_in = RS_WAIT;
               end
            end else begin
               pend_stat_in = RS_ABORT;
            end
         end else if (!table_pol) begin
            if (ocnt_ff == '0) begin
               pend_stat_in = RS_NOTFOUND;
            end else begin
               rel_cnt_en   = 1'b1;
               pend_stat_in = RS_REL;
            end
         end
      end else if (cmd.apply) begin
         pend_we = 1'b1;
         if (is_acq) begin
            if (hit_a_ff) begin
               pend_stat_in = RS_ABORT;
            end else if (wcnt_ff == WCNT_W'(WAITER_SLOTS)) begin
               pend_stat_in = RS_FULL;
            end else begin
               ins_en       = 1'b1;
               pend_stat_in = RS_WAIT;
            end
         end else if (hit_a_ff) begin
            clr_en       = 1'b1;
            pend_stat_in = RS_REL;
         end else if (hit_b_ff) begin
            drop_en      = 1'b1;
            pend_stat_in = RS_REL;
         end else begin
            pend_stat_in = RS_NOTFOUND;
         end
      end else if (cmd.emit && more) begin
         add_en       = 1'b1;
         add_id       = wid_ff[0];
         add_stamp    = wstamp_ff[0];
         add_mode     = head_mode;
         drop_en      = 1'b1;
         drop_pos     = '0;
         pend_we      = 1'b1;
         pend_stat_in = RS_PROMO;
         pend_id_in   = wid_ff[0];
         promo_en_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POL_WAITDIE;
         mode_ff      <= MODE_NONE;
         ocnt_ff      <= '0;
         wcnt_ff      <= '0;
         ovalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
         if (add_en) begin
            mode_ff <= add_mode;
            ocnt_ff <= ocnt_ff + OCNT_W'(1);
            if (table_pol) begin
               ovalid_ff[free_pos] <= 1'b1;
            end
         end else if (rel_cnt_en || clr_en) begin
            ocnt_ff <= ocnt_dec;
            if (ocnt_dec == '0) begin
               mode_ff <= MODE_NONE;
            end
            if (clr_en) begin
               ovalid_ff[pos_a_ff] <= 1'b0;
            end
         end
         if (ins_en) begin
            wcnt_ff <= wcnt_ff + WCNT_W'(1);
         end else if (drop_en) begin
            wcnt_ff <= wcnt_ff - WCNT_W'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (add_en && table_pol) begin
         oid_ff[free_pos]    <= add_id;
         ostamp_ff[free_pos] <= add_stamp;
      end
   end

   for (genvar g = 0; g < WAITER_SLOTS; g++) begin : g_waiter
      localparam int PREV = (g > 0) ? g - 1 : 0;
      localparam int NEXT = (g < WAITER_SLOTS - 1) ? g + 1 : g;
      always_ff @(posedge clock) begin
         if (ins_en) begin
            if (WIDX_W'(g) == ins_pos) begin
               wid_ff[g]    <= id_ff;
               wstamp_ff[g] <= stamp_ff;
               wex_ff[g]    <= (op_ff == OP_EXCL);
            end else if (WIDX_W'(g) > ins_pos) begin
               wid_ff[g]    <= wid_ff[PREV];
               wstamp_ff[g] <= wstamp_ff[PREV];
               wex_ff[g]    <= wex_ff[PREV];
            end
         end else if (drop_en && (WIDX_W'(g) >= drop_pos)) begin
            wid_ff[g]    <= wid_ff[NEXT];
            wstamp_ff[g] <= wstamp_ff[NEXT];
            wex_ff[g]    <= wex_ff[NEXT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         id_ff    <= req_txn_id;
         stamp_ff <= req_start_stamp;
      end
      if (cmd.quick) begin
         sidx_ff  <= '0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         sidx_ff <= sidx_ff + SIDX_W'(1);
         if (o_match && !hit_a_ff) begin
            hit_a_ff <= 1'b1;
            pos_a_ff <= s_o;
         end
         if (w_match && !hit_b_ff) begin
            hit_b_ff <= 1'b1;
            pos_b_ff <= s_w;
         end
      end
      if (pend_we) begin
         pend_stat_ff <= pend_stat_in;
         pend_id_ff   <= pend_id_in;
         promo_en_ff  <= promo_en_in;
      end
      if (cmd.emit) begin
         rsp_status_ff <= pend_stat_ff;
         rsp_id_ff     <= pend_id_ff;
         rsp_last_ff   <= !more;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_subject_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;
endmodule

>>> design/slm_ctrl.sv
`timescale 1ns / 1ps
module slm_ctrl import slm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_opcode,
   output logic            req_ready,
   input  stat_type        stat,
   output cmd_type         cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && (req_opcode != OP_NONE)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = stat.need_scan ? S_SCAN : S_EMIT;
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free && !stat.more) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.quick     = (state_ff == S_DECIDE);
      cmd.scan_step = (state_ff == S_SCAN);
      cmd.apply     = (state_ff == S_APPLY);
      cmd.emit      = (state_ff == S_EMIT) && stat.out_free;
   end
endmodule

>>> design/shared_exclusive_lock_manager.sv
`timescale 1ns / 1ps
// shared/exclusive lock for one record with owner table and waiter queue
// req channel: valid/ready, one transfer per acquire or release request;
//   a request with opcode three is taken and gives no result
// rsp channel: valid/ready, one transfer per result, rsp_last on the final
//   result of a request (a release may add one promoted waiter per result)
// csr: csr_wr_en writes the conflict policy; write only while idle
// flow: a request that needs no table scan goes from the decide state to
//   the emit state, which registers its first result on rsp; a scan (wait-die
//   conflict, or a release under wait-die or calvin) walks one owner and one
//   waiter entry per cycle, then passes through the apply state to emit
// the state machine works on a single request at a time: it takes no new
//   request until the final result of the current one (rsp_last), after any
//   promoted waiters, has been emitted
// reset: lock mode none, owner table and waiter queue empty, policy wait-die
// stall: a result waits in the rsp register; the next request is still taken
//   while it waits, and further results hold until rsp_ready
module shared_exclusive_lock_manager import slm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [ID_W-1:0]    req_txn_id,
   input  logic [STAMP_W-1:0] req_start_stamp,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [ID_W-1:0]    rsp_subject_id,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [POL_W-1:0]   csr_wr_data
);
   `include "shared_exclusive_lock_manager_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   slm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   slm_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_txn_id      (req_txn_id),
      .req_start_stamp (req_start_stamp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_subject_id  (rsp_subject_id),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   `SLM_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready && (req_opcode != OP_NONE), !req_ready)
   `SLM_ASSERT_NOW(a_emit_has_room, clock, reset, cmd.emit, stat.out_free)
   `SLM_ASSERT_NOW(a_scan_blocks_req, clock, reset, cmd.scan_step || cmd.apply, !req_ready && !cmd.emit)
endmodule

>>> tb/shared_exclusive_lock_manager_test.sv
`timescale 1ns / 1ps
module shared_exclusive_lock_manager_test;
   import slm_pkg::*;

   typedef struct {
      logic [OP_W-1:0]    opcode;
      logic [ID_W-1:0]    txn_id;
      logic [STAMP_W-1:0] stamp;
   } lock_req_type;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   subject;
      logic              last;
   } lock_rsp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [OP_W-1:0]    req_opcode;
   logic [ID_W-1:0]    req_txn_id;
   logic [STAMP_W-1:0] req_start_stamp;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [STAT_W-1:0]  rsp_status;
   logic [ID_W-1:0]    rsp_subject_id;
   logic               rsp_last;
   logic               csr_wr_en;
   logic [POL_W-1:0]   csr_wr_data;

   lock_req_type pending_reqs[$];
   lock_rsp_type expected_rsps[$];
   int        errors;
   int        cycles;
   bit        calm;
   bit        stall_kick;
   bit        stall_fired;
   int        stall_left;

   // lock state mirror
   logic [POL_W-1:0]   pol;
   logic [MODE_W-1:0]  mode_held;
   logic [ID_W-1:0]    own_id[OWNER_SLOTS];
   logic [STAMP_W-1:0] own_stamp[OWNER_SLOTS];
   bit                 own_vld[OWNER_SLOTS];
   int                 own_cnt;
   logic [ID_W-1:0]    wt_id[WAITER_SLOTS];
   logic [STAMP_W-1:0] wt_stamp[WAITER_SLOTS];
   bit                 wt_ex[WAITER_SLOTS];
   int                 wt_cnt;

   logic [ID_W-1:0]    pool_id[8];
   logic [STAMP_W-1:0] pool_stamp[8];

   shared_exclusive_lock_manager u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_txn_id(req_txn_id), .req_start_stamp(req_start_stamp),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_subject_id(rsp_subject_id), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit clash(logic [MODE_W-1:0] a, logic [MODE_W-1:0] b);
      if (a == MODE_NONE || b == MODE_NONE) return 1'b0;
      return (a == MODE_EX) || (b == MODE_EX);
   endfunction

   function automatic bit uses_table();
      return (pol == POL_WAITDIE) || (pol == POL_CALVIN);
   endfunction

   function automatic bit grant_owner(logic [ID_W-1:0] id, logic [STAMP_W-1:0] st,
                                      logic [MODE_W-1:0] m);
      int slot;
      slot = -1;
      if (uses_table()) begin
         for (int i = OWNER_SLOTS - 1; i >= 0; i--) if (!own_vld[i]) slot = i;
         if (slot < 0) return 1'b0;
         own_vld[slot] = 1'b1;
         own_id[slot] = id;
         own_stamp[slot] = st;
      end else if (own_cnt >= OWNER_SLOTS) begin
         return 1'b0;
      end
      own_cnt++;
      mode_held = m;
      return 1'b1;
   endfunction

   function automatic void remove_waiter(int pos);
      for (int i = pos; i + 1 < wt_cnt; i++) begin
         wt_id[i] = wt_id[i+1];
         wt_stamp[i] = wt_stamp[i+1];
         wt_ex[i] = wt_ex[i+1];
      end
      wt_cnt--;
   endfunction

   function automatic void insert_waiter(int pos, logic [ID_W-1:0] id,
                                         logic [STAMP_W-1:0] st, bit ex);
      for (int i = wt_cnt; i > pos; i--) begin
         wt_id[i] = wt_id[i-1];
         wt_stamp[i] = wt_stamp[i-1];
         wt_ex[i] = wt_ex[i-1];
      end
      wt_id[pos] = id;
      wt_stamp[pos] = st;
      wt_ex[pos] = ex;
      wt_cnt++;
   endfunction

   function automatic logic [STAT_W-1:0] try_acquire(logic [MODE_W-1:0] m,
                                                     logic [ID_W-1:0] id,
                                                     logic [STAMP_W-1:0] st);
      bit conflict;
      int pos;
      conflict = clash(mode_held, m);
      if (!conflict && wt_cnt > 0) begin
         if (pol == POL_WAITDIE && st < wt_stamp[0]) conflict = 1'b1;
         if (pol == POL_CALVIN) conflict = 1'b1;
      end
      if (!conflict) return grant_owner(id, st, m) ? RS_GRANT : RS_FULL;
      if (pol == POL_WAITDIE) begin
         for (int i = 0; i < OWNER_SLOTS; i++)
            if (own_vld[i] && st > own_stamp[i]) return RS_ABORT;
         if (wt_cnt >= WAITER_SLOTS) return RS_FULL;
         pos = 0;
         while (pos < wt_cnt && st < wt_stamp[pos]) pos++;
         insert_waiter(pos, id, st, m == MODE_EX);
         return RS_WAIT;
      end
      if (pol == POL_CALVIN) begin
         if (wt_cnt >= WAITER_SLOTS) return RS_FULL;
         insert_waiter(wt_cnt, id, st, m == MODE_EX);
         return RS_WAIT;
      end
      return RS_ABORT;
   endfunction

   function automatic logic [STAT_W-1:0] try_release(logic [ID_W-1:0] id);
      if (!uses_table()) begin
         if (own_cnt == 0) return RS_NOTFOUND;
         own_cnt--;
         if (own_cnt == 0) mode_held = MODE_NONE;
         return RS_REL;
      end
      for (int i = 0; i < OWNER_SLOTS; i++) begin
         if (own_vld[i] && own_id[i] == id) begin
            own_vld[i] = 1'b0;
            if (own_cnt > 0) own_cnt--;
            if (own_cnt == 0) mode_held = MODE_NONE;
            return RS_REL;
         end
      end
      for (int i = 0; i < wt_cnt; i++) begin
         if (wt_id[i] == id) begin
            remove_waiter(i);
            return RS_REL;
         end
      end
      return RS_NOTFOUND;
   endfunction

   function automatic void predict_lock(lock_req_type r);
      lock_rsp_type e[$];
      lock_rsp_type x;
      logic [MODE_W-1:0] m;
      logic [ID_W-1:0] wid;
      if (r.opcode == OP_SHARED || r.opcode == OP_EXCL) begin
         x.status = try_acquire(r.opcode == OP_SHARED ? MODE_SH : MODE_EX,
                                r.txn_id, r.stamp);
         x.subject = r.txn_id;
         x.last = 1'b0;
         e.push_back(x);
      end else if (r.opcode == OP_RELEASE) begin
         x.status = try_release(r.txn_id);
         x.subject = r.txn_id;
         x.last = 1'b0;
         e.push_back(x);
         while (wt_cnt > 0) begin
            m = wt_ex[0] ? MODE_EX : MODE_SH;
            wid = wt_id[0];
            if (clash(mode_held, m)) break;
            if (!grant_owner(wid, wt_stamp[0], m)) break;
            remove_waiter(0);
            x.status = RS_PROMO;
            x.subject = wid;
            e.push_back(x);
         end
      end
      if (e.size() > 0) e[e.size()-1].last = 1'b1;
      foreach (e[i]) expected_rsps.push_back(e[i]);
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   // request driver
   always @(posedge clock) begin
      lock_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            r.opcode = req_opcode;
            r.txn_id = req_txn_id;
            r.stamp = req_start_stamp;
            predict_lock(r);
         end
         if (req_valid && !req_ready) begin
            req_valid <= 1'b1;
         end else if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_opcode <= r.opcode;
            req_txn_id <= r.txn_id;
            req_start_stamp <= r.stamp;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_fired <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_kick && !stall_fired) begin
         stall_left <= 400;
         stall_fired <= 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      lock_rsp_type x;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d id %h",
                                         rsp_status, rsp_subject_id));
            end else begin
               x = expected_rsps.pop_front();
               if (rsp_status !== x.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_status, x.status));
               if (rsp_subject_id !== x.subject)
                  report_mismatch($sformatf("subject %h, want %h", rsp_subject_id, x.subject));
               if (rsp_last !== x.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_last, x.last));
            end
         end
         rsp_ready <= (stall_left == 0) && (calm || $urandom_range(99) >= 32);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic add_req(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [STAMP_W-1:0] st);
      lock_req_type r;
      r.opcode = op;
      r.txn_id = id;
      r.stamp = st;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_policy(logic [POL_W-1:0] p);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pol = p;
   endtask

   task automatic random_reqs(int n);
      int k;
      logic [OP_W-1:0] op;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(7);
         case ($urandom_range(99)) inside
            [0:39]:  op = OP_SHARED;
            [40:59]: op = OP_EXCL;
            [60:94]: op = OP_RELEASE;
            default: op = OP_NONE;
         endcase
         if ($urandom_range(19) == 0) begin
            add_req(OP_W'($urandom_range(3)), $urandom, STAMP_W'({$urandom, $urandom}));
         end else begin
            add_req(op, pool_id[k], pool_stamp[k]);
            if ($urandom_range(9) == 0) begin
               pool_id[k] = $urandom;
               pool_stamp[k] = $urandom_range(3) == 0 ? STAMP_W'({$urandom, $urandom})
                                                      : STAMP_W'($urandom_range(1000));
            end
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_NONE;
      req_txn_id = '0;
      req_start_stamp = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = POL_WAITDIE;
      errors = 0;
      cycles = 0;
      calm = 1'b0;
      stall_kick = 1'b0;
      pol = POL_WAITDIE;
      mode_held = MODE_NONE;
      own_cnt = 0;
      wt_cnt = 0;
      foreach (own_vld[i]) own_vld[i] = 1'b0;
      foreach (pool_id[i]) begin
         pool_id[i] = $urandom;
         pool_stamp[i] = STAMP_W'($urandom_range(1000));
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // wait-die after reset: grant, wait, abort, promote, not found, ignored
      add_req(OP_SHARED, 32'h0000_0000, 48'd100);
      add_req(OP_SHARED, 32'hffff_ffff, 48'd50);
      add_req(OP_EXCL, 32'h1234_5678, 48'hffff_ffff_ffff);
      add_req(OP_EXCL, 32'h0000_0007, 48'd0);
      add_req(OP_SHARED, 32'h0000_0009, 48'd0);
      add_req(OP_RELEASE, 32'hdead_beef, 48'd0);
      add_req(OP_NONE, 32'hffff_ffff, 48'hffff_ffff_ffff);
      add_req(OP_RELEASE, 32'h0000_0000, 48'd0);
      add_req(OP_RELEASE, 32'hffff_ffff, 48'd0);
      add_req(OP_RELEASE, 32'h0000_0009, 48'd0);
      add_req(OP_RELEASE, 32'h0000_0007, 48'd0);

      // no-wait: fill the owner count, then conflict and empty releases
      set_policy(POL_NOWAIT);
      for (int i = 0; i < 17; i++) add_req(OP_SHARED, ID_W'(i), STAMP_W'(i));
      add_req(OP_EXCL, 32'h55, 48'd1);
      for (int i = 0; i < 18; i++) add_req(OP_RELEASE, ID_W'(i), 48'd0);

      // calvin: fill the waiter queue behind an exclusive owner, then release
      set_policy(POL_CALVIN);
      add_req(OP_EXCL, 32'haaaa_aaaa, 48'd5);
      for (int i = 0; i < 17; i++) add_req(OP_SHARED, ID_W'(32'h100 + i), STAMP_W'(i));
      add_req(OP_RELEASE, 32'h105, 48'd0);
      add_req(OP_RELEASE, 32'haaaa_aaaa, 48'd0);

      calm = 1'b1;
      random_reqs(30);
      drain();
      calm = 1'b0;
      stall_kick = 1'b1;
      random_reqs(40);
      set_policy(POL_WAITDIE);
      random_reqs(50);
      set_policy(POL_SPARE);
      random_reqs(30);
      set_policy(POL_NOWAIT);
      random_reqs(40);
      set_policy(POL_CALVIN);
      random_reqs(50);
      set_policy(POL_WAITDIE);
      random_reqs(40);
      drain();
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

>>> shared_exclusive_lock_manager.f
+incdir+design
design/slm_pkg.sv
design/slm_datapath.sv
design/slm_ctrl.sv
design/shared_exclusive_lock_manager.sv
tb/shared_exclusive_lock_manager_test.sv
